>>> rtl/mfek_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared types and constants of the maximum-flow engine.
// ----------------------------------------------------------------------------
package mfek_pkg;

  localparam int unsigned NODE_COUNT = 16;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned FLOW_W  = 17;
  localparam int unsigned TOTAL_W = 20;
  localparam logic [CAP_W-1:0]   SRC_BOTTLENECK = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = '1;

  typedef enum logic [0:0] {
    ACT_WRITE = 1'b0,
    ACT_RUN   = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,    // sweep flow memory to zero
    ST_BFS_INIT, // seed search from source
    ST_POP,      // take next node off the queue
    ST_SCAN_RD,  // issue read of capacity and flow for (u,v)
    ST_SCAN_EV,  // evaluate residual of (u,v)
    ST_AUG_RD,   // read forward flow along the path
    ST_AUG_FWD,  // write forward flow, read reverse flow
    ST_AUG_REV,  // write reverse flow
    ST_DONE      // hold result until taken
  } state_t;

endpackage : mfek_pkg
`default_nettype wire

>>> rtl/max_flow_edmonds_karp_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_unit
// Edmonds-Karp maximum flow over a node-pair capacity memory.
// ----------------------------------------------------------------------------
// Usage: the in_ channel carries write and run transactions. A write
// transaction (in_action = 0) stores in_capacity for pair (in_from_node,
// in_to_node) and gives no result. A run transaction (in_action = 1)
// clears the flow memory, then repeats a breadth-first search in which
// every (u,v) pair takes a read and an evaluate step on the single
// capacity/flow memory port pair, and augments along the path with a
// read, a forward write and a reverse write per edge.
// The result appears on out_max_flow in an output register; the engine
// accepts no new transaction until it is taken, so a stalled receiver
// simply holds the block. After reset the capacity memory is swept to
// zero, during which in_ready stays low.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_action,
  input  wire  [3:0]                      in_from_node,
  input  wire  [3:0]                      in_to_node,
  input  wire  [mfek_pkg::CAP_W-1:0]      in_capacity,
  input  wire  [3:0]                      in_source_node,
  input  wire  [3:0]                      in_sink_node,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [mfek_pkg::TOTAL_W-1:0]    out_max_flow
);
  import mfek_pkg::*;

  localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned AW = 2 * NW;
  localparam int unsigned DEPTH = NODE_COUNT * NODE_COUNT;
  localparam int unsigned QW = $clog2(NODE_COUNT + 1);

  // memories
  logic [CAP_W-1:0]  cap_mem  [DEPTH];
  logic [FLOW_W-1:0] flow_mem [DEPTH];
  // per-node search tables, kept in registers
  logic [NODE_COUNT-1:0][NW-1:0]    par_r;
  logic [NODE_COUNT-1:0][CAP_W-1:0] bn_r;
  logic [NODE_COUNT-1:0][NW-1:0]    q_r;
  logic [NODE_COUNT-1:0] visited_r, visited_nxt;

  state_t state_r, state_nxt;
  logic             init_r, init_nxt;
  logic [AW:0]      clr_r, clr_nxt;
  logic [NW-1:0]    src_r, src_nxt, dst_r, dst_nxt;
  logic [NW-1:0]    u_r, u_nxt, v_r, v_nxt, node_r, node_nxt, prev_r, prev_nxt;
  logic [QW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [CAP_W-1:0] bnu_r, bnu_nxt, push_r, push_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic             busy_r, busy_nxt;
  logic             ovalid_r, ovalid_nxt;

  // memory ports
  logic             cap_we, flow_we;
  logic [AW-1:0]    cap_wa, cap_ra, flow_wa, flow_ra;
  logic [CAP_W-1:0] cap_wd, cap_rd;
  logic [FLOW_W-1:0] flow_wd, flow_rd;
  logic             par_we, bn_we, q_we;
  logic [NW-1:0]    par_wa, par_wd, bn_wa, q_wa, q_wd, par_ra, q_ra;
  logic [CAP_W-1:0] bn_wd;

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_rd <= cap_mem[cap_ra];
    if (flow_we) flow_mem[flow_wa] <= flow_wd;
    flow_rd <= flow_mem[flow_ra];
    if (par_we) par_r[par_wa] <= par_wd;
    if (bn_we) bn_r[bn_wa] <= bn_wd;
    if (q_we) q_r[q_wa] <= q_wd;
  end

  // small tables read combinationally at one address each
  logic [NW-1:0] q_rd, par_rd;
  assign q_rd   = q_r[q_ra];
  assign par_rd = par_r[par_ra];

  function automatic logic [AW-1:0] pair(input logic [NW-1:0] a, input logic [NW-1:0] b);
    return {a, b};
  endfunction

  logic in_fire, out_fire;
  logic in_ok_w, in_ok_r;
  logic signed [FLOW_W+1:0] resid;
  logic [CAP_W-1:0] nb;
  logic [TOTAL_W:0] tsum;

  assign in_ready  = init_r && !busy_r && !ovalid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = ovalid_r && out_ready;
  assign out_valid = ovalid_r;
  assign out_max_flow = total_r;

  assign in_ok_w = ({28'd0, in_from_node} < 32'(NODE_COUNT))
                && ({28'd0, in_to_node} < 32'(NODE_COUNT));
  assign in_ok_r = ({28'd0, in_source_node} < 32'(NODE_COUNT))
                && ({28'd0, in_sink_node} < 32'(NODE_COUNT));

  assign resid = $signed({3'b000, cap_rd}) - $signed({{2{flow_rd[FLOW_W-1]}}, flow_rd});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      init_r   <= 1'b0;
      clr_r    <= '0;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      visited_r <= '0;
      total_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      init_r   <= init_nxt;
      clr_r    <= clr_nxt;
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      visited_r <= visited_nxt;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt; dst_r <= dst_nxt;
    u_r <= u_nxt; v_r <= v_nxt; node_r <= node_nxt; prev_r <= prev_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt;
    bnu_r <= bnu_nxt; push_r <= push_nxt;
  end

  always_comb begin
    state_nxt = state_r; init_nxt = init_r; clr_nxt = clr_r;
    busy_nxt = busy_r; ovalid_nxt = ovalid_r; visited_nxt = visited_r;
    total_nxt = total_r;
    src_nxt = src_r; dst_nxt = dst_r; u_nxt = u_r; v_nxt = v_r;
    node_nxt = node_r; prev_nxt = prev_r; head_nxt = head_r; tail_nxt = tail_r;
    bnu_nxt = bnu_r; push_nxt = push_r;
    cap_we = 1'b0; cap_wa = pair(in_from_node[NW-1:0], in_to_node[NW-1:0]);
    cap_wd = in_capacity; cap_ra = pair(u_r, v_r);
    flow_we = 1'b0; flow_wa = clr_r[AW-1:0]; flow_wd = '0; flow_ra = pair(u_r, v_r);
    par_we = 1'b0; par_wa = v_r; par_wd = u_r; par_ra = node_r;
    bn_we = 1'b0; bn_wa = v_r; bn_wd = '0;
    q_we = 1'b0; q_wa = tail_r[NW-1:0]; q_wd = v_r; q_ra = head_r[NW-1:0];
    nb = '0; tsum = '0;

    if (out_fire) ovalid_nxt = 1'b0;

    if (!init_r) begin
      // sweep capacity memory to zero after reset
      cap_we = 1'b1; cap_wa = clr_r[AW-1:0]; cap_wd = '0;
      clr_nxt = clr_r + 1'b1;
      if (clr_r == (AW+1)'(DEPTH - 1)) begin
        init_nxt = 1'b1; clr_nxt = '0;
      end
    end else if (!busy_r) begin
      if (in_fire) begin
        if (action_t'(in_action) == ACT_WRITE) begin
          cap_we = in_ok_w;
        end else if (!in_ok_r) begin
          total_nxt = '0; ovalid_nxt = 1'b1;
        end else begin
          src_nxt = in_source_node[NW-1:0]; dst_nxt = in_sink_node[NW-1:0];
          total_nxt = '0; clr_nxt = '0; busy_nxt = 1'b1; state_nxt = ST_CLEAR;
        end
      end
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          flow_we = 1'b1; flow_wa = clr_r[AW-1:0]; flow_wd = '0;
          clr_nxt = clr_r + 1'b1;
          if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_BFS_INIT;
        end
        ST_BFS_INIT: begin
          visited_nxt = '0; visited_nxt[src_r] = 1'b1;
          par_we = 1'b1; par_wa = src_r; par_wd = src_r;
          bn_we = 1'b1; bn_wa = src_r; bn_wd = SRC_BOTTLENECK;
          q_we = 1'b1; q_wa = '0; q_wd = src_r;
          head_nxt = '0; tail_nxt = QW'(1);
          state_nxt = ST_POP;
        end
        ST_POP: begin
          if (head_r < tail_r) begin
            u_nxt = q_rd; bnu_nxt = bn_r[q_rd];
            head_nxt = head_r + 1'b1; v_nxt = '0;
            state_nxt = ST_SCAN_RD;
          end else begin
            // no path remains
            ovalid_nxt = 1'b1; busy_nxt = 1'b0; state_nxt = ST_DONE;
          end
        end
        ST_SCAN_RD: begin
          cap_ra = pair(u_r, v_r); flow_ra = pair(u_r, v_r);
          state_nxt = ST_SCAN_EV;
        end
        ST_SCAN_EV: begin
          if (!visited_r[v_r] && resid > 0) begin
            nb = (resid < $signed({3'b000, bnu_r})) ? resid[CAP_W-1:0] : bnu_r;
            visited_nxt[v_r] = 1'b1;
            par_we = 1'b1; bn_we = 1'b1; bn_wd = nb;
            if (v_r == dst_r) begin
              push_nxt = nb;
              tsum = {1'b0, total_r} + (TOTAL_W+1)'(nb);
              total_nxt = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
              node_nxt = dst_r;
              state_nxt = ST_AUG_RD;
            end else begin
              if (tail_r < QW'(NODE_COUNT)) begin
                q_we = 1'b1; tail_nxt = tail_r + 1'b1;
              end
            end
          end
          if (state_nxt == ST_SCAN_EV) begin
            if (v_r == NW'(NODE_COUNT - 1)) state_nxt = ST_POP;
            else begin
              v_nxt = v_r + 1'b1; state_nxt = ST_SCAN_RD;
            end
          end
        end
        ST_AUG_RD: begin
          // one flow port: read forward now, reverse next
          if (node_r == src_r) begin
            state_nxt = ST_BFS_INIT;
          end else begin
            prev_nxt = par_rd;
            flow_ra = pair(par_rd, node_r);
            state_nxt = ST_AUG_FWD;
          end
        end
        ST_AUG_FWD: begin
          flow_we = 1'b1; flow_wa = pair(prev_r, node_r);
          flow_wd = flow_rd + FLOW_W'(push_r);
          flow_ra = pair(node_r, prev_r);
          state_nxt = ST_AUG_REV;
        end
        ST_AUG_REV: begin
          flow_we = 1'b1; flow_wa = pair(node_r, prev_r);
          flow_wd = flow_rd - FLOW_W'(push_r);
          node_nxt = prev_r;
          state_nxt = ST_AUG_RD;
        end
        ST_DONE: state_nxt = ST_DONE;
        default: state_nxt = ST_DONE;
      endcase
    end
  end

endmodule : max_flow_edmonds_karp_unit
`default_nettype wire

>>> rtl/mfek_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfek_checker
// Port-level checks on the maximum-flow engine.
// ----------------------------------------------------------------------------
module mfek_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_action,
  input wire        out_valid,
  input wire        out_ready,
  input wire [19:0] out_max_flow
);

  // a result waits with a steady value until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_flow))
    else $error("result dropped or changed while stalled");

  // no new transaction while a result is pending
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // a write transaction never yields a result next cycle
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_action && !out_valid |=> !out_valid)
    else $error("result after write transaction");

  // no output straight after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule : mfek_checker

bind max_flow_edmonds_karp_unit mfek_checker u_mfek_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_action(in_action), .out_valid(out_valid), .out_ready(out_ready),
  .out_max_flow(out_max_flow)
);
`default_nettype wire
